### rtl/core/bounded_positional_list_core_defines.svh
// assertion macros for the bounded positional list core
// no dependencies
`ifndef BOUNDED_POSITIONAL_LIST_CORE_DEFINES_SVH
`define BOUNDED_POSITIONAL_LIST_CORE_DEFINES_SVH
// clocked check with synchronous reset disable
`define BPL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// a stalled word stays offered and unchanged on the next cycle
`define BPL_ASSERT_HOLD(label, clk, rst, vld, stl, sig, msg) \
   label: assert property (@(posedge clk) disable iff (rst) \
      (vld && stl) |=> (vld && $stable(sig))) else $error(msg);
`endif

### rtl/core/bpl_pkg.sv
// package for the bounded positional list core
// types, command codes and sizes; no dependencies
package bpl_pkg;
   localparam int DEPTH = 128;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = 64;

   typedef enum logic [3:0] {
      CMD_INS_TAIL = 4'd0, CMD_INS_HEAD = 4'd1, CMD_INS_AT = 4'd2,
      CMD_REM_TAIL = 4'd3, CMD_REM_HEAD = 4'd4, CMD_REM_AT = 4'd5,
      CMD_SWAP = 4'd6, CMD_READ = 4'd7, CMD_FIND_CODE = 4'd8,
      CMD_FIND_MIN = 4'd9, CMD_STATUS = 4'd10
   } cmd_type;

   typedef struct packed {
      logic [3:0]  cmd;
      logic [6:0]  pos_a;
      logic [6:0]  pos_b;
      logic [31:0] item_code;
      logic [31:0] item_price;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [6:0]  found_pos;
      logic [31:0] found_code;
      logic [31:0] found_price;
      logic [7:0]  entry_count;
      logic        is_empty;
      logic        is_full;
   } rsp_type;
endpackage

### rtl/core/bpl_ram.sv
// generic single-port-write, one-read synchronous ram
// registered read data; no dependencies
module bpl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH_W = 128
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH_W)-1:0] wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH_W)-1:0] rd_addr,
   output logic [WIDTH-1:0]           rd_data
);
   logic [WIDTH-1:0] mem [DEPTH_W];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

### rtl/core/bounded_positional_list_core.sv
// bounded positional list: ordered list of code/price entries in one ram
// top level; uses bpl_pkg, bpl_ram and bounded_positional_list_core_defines.svh
//
// usage
//  - req channel (req_valid/req_stall/req_word) carries one command word,
//    accepted when req_valid is high and req_stall low
//  - rsp channel (rsp_valid/rsp_stall/rsp_word) returns exactly one result
//    word per command, in order
//  - one command at a time; the single ram read port sets the timing
//  - insert and remove: one read and one write-back per moved entry
//  - swap: both entries read, then both written back
//  - searches scan the entries in order, up to DEPTH of them
//  - reset clears the fill count and the control; ram contents are left as
//    they are, since no read goes past the count
//  - a stalled result holds in the output register; the next command is
//    accepted and worked meanwhile, and its result waits in the done state
`include "bounded_positional_list_core_defines.svh"
module bounded_positional_list_core
   import bpl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);
   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_SHIFT_RD, S_SHIFT_WR, S_FINAL_WR, S_SWAP_RB,
      S_SWAP_WA, S_SWAP_WB, S_READ_WAIT, S_SCAN, S_DONE
   } state_type;

   state_type   state_ff;
   // input skid word
   logic        hold_valid_ff;
   req_type     hold_ff;
   req_type     cur_ff;
   logic [CW-1:0] count_ff;
   // walk pointer and bound
   logic [CW-1:0] idx_ff;
   logic [CW-1:0] stop_ff;
   logic        up_ff;        // shift direction, up for insert, down for remove
   logic        scan_min_ff;
   logic        scan_pend_ff; // read data valid for a scanned index
   logic [AW-1:0] scan_pos_ff;
   logic [EW-1:0] best_ff;
   logic [AW-1:0] best_pos_ff;
   logic        best_hit_ff;
   logic        ok_ff;        // success decided at decode
   logic [EW-1:0] tmp_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, rd_data;

   bpl_ram #(.WIDTH(EW), .DEPTH_W(DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign req_stall = hold_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   logic [CW-1:0] pa_w, pb_w;
   assign pa_w = CW'(cur_ff.pos_a);
   assign pb_w = CW'(cur_ff.pos_b);

   // ram port control, by state
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = rd_data;
      rd_addr = idx_ff[AW-1:0];
      unique case (state_ff)
         // first swap entry or the read entry, data back in the next state
         S_DECODE:   rd_addr = cur_ff.pos_a;
         S_SHIFT_RD: rd_addr = up_ff ? AW'(idx_ff - 1'b1) : AW'(idx_ff + 1'b1);
         S_SHIFT_WR: wr_en = 1'b1;
         S_FINAL_WR: begin
            wr_en   = 1'b1;
            wr_data = {cur_ff.item_code, cur_ff.item_price};
         end
         S_SWAP_RB: rd_addr = cur_ff.pos_b;
         S_SWAP_WA: begin
            wr_en = 1'b1; wr_addr = cur_ff.pos_a;
         end
         S_SWAP_WB: begin
            wr_en = 1'b1; wr_addr = cur_ff.pos_b; wr_data = tmp_ff;
         end
         default: rd_addr = idx_ff[AW-1:0];
      endcase
   end

   // result word built from the decode outcome and the search pick
   always_comb begin
      rsp_in             = '0;
      rsp_in.ok          = ok_ff | best_hit_ff;
      rsp_in.found_pos   = best_hit_ff ? best_pos_ff : '0;
      rsp_in.found_code  = best_hit_ff ? best_ff[63:32] : '0;
      rsp_in.found_price = best_hit_ff ? best_ff[31:0] : '0;
      rsp_in.entry_count = 8'(count_ff);
      rsp_in.is_empty    = (count_ff == '0);
      rsp_in.is_full     = (count_ff == CW'(DEPTH));
   end

   logic rsp_free;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         hold_valid_ff <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         scan_pend_ff  <= 1'b0;
      end else begin
         if (state_ff == S_DONE && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (req_valid && !hold_valid_ff) begin
            hold_valid_ff <= 1'b1;
            hold_ff       <= req_word;
         end
         unique case (state_ff)
            S_IDLE: if (hold_valid_ff) begin
               cur_ff        <= hold_ff;
               hold_valid_ff <= 1'b0;
               state_ff      <= S_DECODE;
            end
            S_DECODE: begin
               logic      ok;
               state_type nxt;
               ok  = 1'b0;
               nxt = S_DONE;
               best_hit_ff <= 1'b0;
               unique case (cur_ff.cmd)
                  CMD_INS_TAIL, CMD_INS_HEAD, CMD_INS_AT: begin
                     logic [CW-1:0] at;
                     at = (cur_ff.cmd == CMD_INS_TAIL) ? count_ff :
                          (cur_ff.cmd == CMD_INS_HEAD) ? '0 : pa_w;
                     if (count_ff < CW'(DEPTH) && at <= count_ff) begin
                        ok      = 1'b1;
                        up_ff   <= 1'b1;
                        idx_ff  <= count_ff;
                        stop_ff <= at;
                        nxt     = (count_ff > at) ? S_SHIFT_RD : S_FINAL_WR;
                     end
                  end
                  CMD_REM_TAIL, CMD_REM_HEAD, CMD_REM_AT: begin
                     logic [CW-1:0] at;
                     at = (cur_ff.cmd == CMD_REM_TAIL) ? count_ff - 1'b1 :
                          (cur_ff.cmd == CMD_REM_HEAD) ? '0 : pa_w;
                     if (count_ff != '0 && at < count_ff) begin
                        ok      = 1'b1;
                        up_ff   <= 1'b0;
                        idx_ff  <= at;
                        stop_ff <= count_ff - 1'b1;
                        if (at + 1'b1 < count_ff) nxt = S_SHIFT_RD;
                        else count_ff <= count_ff - 1'b1;
                     end
                  end
                  CMD_SWAP: if (pa_w < count_ff && pb_w < count_ff) begin
                     ok     = 1'b1;
                     idx_ff <= pa_w;
                     nxt    = S_SWAP_RB;
                  end
                  CMD_READ: if (pa_w < count_ff) begin
                     idx_ff      <= pa_w;
                     best_pos_ff <= cur_ff.pos_a;
                     nxt         = S_READ_WAIT;
                  end
                  CMD_FIND_CODE, CMD_FIND_MIN: if (count_ff != '0) begin
                     scan_min_ff  <= (cur_ff.cmd == CMD_FIND_MIN);
                     idx_ff       <= '0;
                     scan_pend_ff <= 1'b0;
                     nxt          = S_SCAN;
                  end
                  CMD_STATUS: ok = 1'b1;
                  default: ;
               endcase
               ok_ff    <= ok;
               state_ff <= nxt;
            end
            S_SHIFT_RD: state_ff <= S_SHIFT_WR;
            S_SHIFT_WR: begin
               if (up_ff) begin
                  if (idx_ff - 1'b1 == stop_ff) state_ff <= S_FINAL_WR;
                  else state_ff <= S_SHIFT_RD;
                  idx_ff <= idx_ff - 1'b1;
               end else begin
                  if (idx_ff + 1'b1 == stop_ff) begin
                     count_ff <= count_ff - 1'b1;
                     state_ff <= S_DONE;
                  end else state_ff <= S_SHIFT_RD;
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_FINAL_WR: begin
               count_ff <= count_ff + 1'b1;
               state_ff <= S_DONE;
            end
            // read a issued in decode, read b now
            S_SWAP_RB: begin
               tmp_ff   <= rd_data;
               state_ff <= S_SWAP_WA;
            end
            S_SWAP_WA: state_ff <= S_SWAP_WB;
            S_SWAP_WB: state_ff <= S_DONE;
            S_READ_WAIT: begin
               best_ff     <= rd_data;
               best_hit_ff <= 1'b1;
               state_ff    <= S_DONE;
            end
            S_SCAN: begin
               logic fin;
               fin = 1'b0;
               if (scan_pend_ff) begin
                  if (scan_min_ff) begin
                     if (!best_hit_ff || rd_data[31:0] < best_ff[31:0]) begin
                        best_ff <= rd_data; best_pos_ff <= scan_pos_ff;
                        best_hit_ff <= 1'b1;
                     end
                  end else if (rd_data[63:32] == cur_ff.item_code) begin
                     best_ff <= rd_data; best_pos_ff <= scan_pos_ff;
                     best_hit_ff <= 1'b1; fin = 1'b1;
                  end
                  if (CW'(scan_pos_ff) + 1'b1 == count_ff) fin = 1'b1;
               end
               scan_pend_ff <= !fin && idx_ff < count_ff;
               scan_pos_ff  <= idx_ff[AW-1:0];
               idx_ff       <= idx_ff + 1'b1;
               if (fin) state_ff <= S_DONE;
            end
            S_DONE: if (rsp_free) begin
               rsp_ff   <= rsp_in;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // count never passes depth
   `BPL_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(DEPTH), "count beyond depth")
   // a result is only raised from the done state
   `BPL_ASSERT(a_rsp_src, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE,
      "result without done")
   // writes only in write states
   `BPL_ASSERT(a_wr_state, clock, reset,
      wr_en |-> (state_ff == S_SHIFT_WR || state_ff == S_FINAL_WR ||
                 state_ff == S_SWAP_WA || state_ff == S_SWAP_WB), "stray ram write")
   // a stalled result word is held
   `BPL_ASSERT_HOLD(a_rsp_hold, clock, reset, rsp_valid_ff, rsp_stall, rsp_ff, "stalled result changed")
endmodule

### bench/tb_bounded_positional_list_core.sv
// testbench for bounded_positional_list_core: directed and random command words
// checked against an in-bench list model; depends on bpl_pkg and the core rtl
`timescale 1ns / 1ps

module tb_bounded_positional_list_core
   import bpl_pkg::*;
();

   // list model plus queue of expected result words
   class list_scoreboard;
      logic [31:0] codes[DEPTH];
      logic [31:0] prices[DEPTH];
      int unsigned fill;
      rsp_type pending[$];
      int mismatches;

      function void clear();
         fill = 0;
         pending.delete();
         mismatches = 0;
      endfunction

      function void note_request(req_type r);
         rsp_type res;
         int unsigned at;
         int unsigned i;
         logic [31:0] tc;
         logic [31:0] tp;
         bit hit;
         res = '0;
         hit = 0;
         case (r.cmd)
            CMD_INS_TAIL, CMD_INS_HEAD, CMD_INS_AT: begin
               at = (r.cmd == CMD_INS_TAIL) ? fill : (r.cmd == CMD_INS_HEAD) ? 0 : r.pos_a;
               if (fill < DEPTH && at <= fill) begin
                  for (i = fill; i > at; i--) begin
                     codes[i] = codes[i-1];
                     prices[i] = prices[i-1];
                  end
                  codes[at] = r.item_code;
                  prices[at] = r.item_price;
                  fill++;
                  res.ok = 1;
               end
            end
            CMD_REM_TAIL, CMD_REM_HEAD, CMD_REM_AT: begin
               at = (r.cmd == CMD_REM_TAIL) ? fill - 1 : (r.cmd == CMD_REM_HEAD) ? 0 : r.pos_a;
               if (fill > 0 && at < fill) begin
                  for (i = at; i + 1 < fill; i++) begin
                     codes[i] = codes[i+1];
                     prices[i] = prices[i+1];
                  end
                  fill--;
                  res.ok = 1;
               end
            end
            CMD_SWAP: begin
               if (r.pos_a < fill && r.pos_b < fill) begin
                  tc = codes[r.pos_a];
                  tp = prices[r.pos_a];
                  codes[r.pos_a] = codes[r.pos_b];
                  prices[r.pos_a] = prices[r.pos_b];
                  codes[r.pos_b] = tc;
                  prices[r.pos_b] = tp;
                  res.ok = 1;
               end
            end
            CMD_READ: begin
               if (r.pos_a < fill) begin
                  res.found_pos = r.pos_a;
                  res.found_code = codes[r.pos_a];
                  res.found_price = prices[r.pos_a];
                  res.ok = 1;
               end
            end
            CMD_FIND_CODE: begin
               for (i = 0; i < fill && !hit; i++) begin
                  if (codes[i] == r.item_code) begin
                     hit = 1;
                     res.found_pos = i[6:0];
                     res.found_code = codes[i];
                     res.found_price = prices[i];
                     res.ok = 1;
                  end
               end
            end
            CMD_FIND_MIN: begin
               if (fill > 0) begin
                  // first lowest price wins, so only a strict drop moves the pick
                  res.found_pos = 0;
                  res.found_code = codes[0];
                  res.found_price = prices[0];
                  for (i = 1; i < fill; i++) begin
                     if (prices[i] < res.found_price) begin
                        res.found_pos = i[6:0];
                        res.found_code = codes[i];
                        res.found_price = prices[i];
                     end
                  end
                  res.ok = 1;
               end
            end
            CMD_STATUS: res.ok = 1;
            default: ;
         endcase
         res.entry_count = fill[7:0];
         res.is_empty = (fill == 0);
         res.is_full = (fill == DEPTH);
         pending.push_back(res);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: expected ok=%b pos=%0d code=%h price=%h cnt=%0d e=%b f=%b",
                        want.ok, want.found_pos, want.found_code, want.found_price,
                        want.entry_count, want.is_empty, want.is_full);
               $display("          actual   ok=%b pos=%0d code=%h price=%h cnt=%0d e=%b f=%b",
                        got.ok, got.found_pos, got.found_code, got.found_price,
                        got.entry_count, got.is_empty, got.is_full);
            end
         end
      endfunction
   endclass

   localparam int WATCHDOG_LIMIT = 20000;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_word;

   list_scoreboard board;
   int idle_cycles = 0;
   bit rsp_quiet = 0;

   bounded_positional_list_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   always #10 clock = ~clock;

   // random word biased so positions mostly fall near the live part of the list
   function automatic req_type random_word(int unsigned fill, int unsigned cmd_hi);
      req_type w;
      int unsigned sel;
      w.cmd = 4'($urandom_range(0, cmd_hi));
      sel = $urandom_range(0, 9);
      w.pos_a = (sel < 7) ? 7'($urandom_range(0, fill)) : 7'($urandom);
      w.pos_b = (sel < 8) ? 7'($urandom_range(0, fill)) : 7'($urandom);
      // small code space so searches hit often, sometimes full range
      w.item_code = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 15));
      w.item_price = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 50));
      return w;
   endfunction

   // present one word, with a random gap before it, and hold until accepted
   // valid stays high after acceptance; a gap or the caller drops it
   task automatic send_word(req_type w, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(w);
   endtask

   task automatic send_cmd(cmd_type c, int pa, int pb, logic [31:0] code, logic [31:0] price);
      req_type w;
      w.cmd = c;
      w.pos_a = 7'(pa);
      w.pos_b = 7'(pb);
      w.item_code = code;
      w.item_price = price;
      send_word(w, 0);
   endtask

   // result side: a random wait drawn per word, with runs of no stalling
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            board.check_result(rsp_word);
            hold = rsp_quiet ? 0 : $urandom_range(0, 11);
         end
         if (hold > 0) begin
            rsp_stall <= 1;
            hold--;
         end else rsp_stall <= 0;
      end
   end

   // watchdog: cycles without any accepted word on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_bounded_positional_list_core NOT OK");
         $finish;
      end
   end

   initial begin
      req_type w;
      int n;
      board = new();
      board.clear();
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty-list failures first
      send_cmd(CMD_REM_TAIL, 0, 0, 0, 0);
      send_cmd(CMD_REM_HEAD, 0, 0, 0, 0);
      send_cmd(CMD_FIND_MIN, 0, 0, 0, 0);
      send_cmd(CMD_READ, 0, 0, 0, 0);
      send_cmd(CMD_STATUS, 0, 0, 0, 0);
      send_cmd(CMD_INS_AT, 1, 0, 1, 1);
      send_cmd(CMD_INS_TAIL, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_cmd(CMD_INS_HEAD, 0, 0, 32'h0, 32'h0);
      send_cmd(CMD_INS_AT, 2, 0, 32'h8000_0000, 32'h0);
      send_cmd(CMD_FIND_MIN, 0, 0, 0, 0);
      send_cmd(CMD_FIND_CODE, 0, 0, 32'h8000_0000, 0);
      send_cmd(CMD_FIND_CODE, 0, 0, 32'h1234_5678, 0);
      send_cmd(CMD_SWAP, 0, 2, 0, 0);
      send_cmd(CMD_SWAP, 0, 3, 0, 0);
      send_cmd(CMD_READ, 2, 0, 0, 0);
      send_cmd(CMD_READ, 127, 0, 0, 0);
      send_cmd(CMD_REM_AT, 1, 0, 0, 0);
      send_cmd(CMD_REM_AT, 5, 0, 0, 0);
      w = '0;
      w.cmd = 4'd15;
      w.pos_a = 7'h7F;
      w.pos_b = 7'h7F;
      send_word(w, 0);
      w.cmd = 4'd11;
      send_word(w, 0);

      // fill to the limit, no gaps so this goes quickly
      rsp_quiet = 1;
      while (board.fill < DEPTH) begin
         w = random_word(board.fill, 0);
         w.cmd = CMD_INS_TAIL;
         send_word(w, 1);
      end
      rsp_quiet = 0;
      send_cmd(CMD_INS_HEAD, 0, 0, 5, 5);
      send_cmd(CMD_FIND_MIN, 0, 0, 0, 0);
      send_cmd(CMD_SWAP, 127, 0, 0, 0);
      send_cmd(CMD_REM_AT, 127, 0, 0, 0);
      req_valid <= 0;

      // hold off until everything outstanding has come back
      while (board.pending.size() != 0) @(posedge clock);

      // random part: phases that push the list up and down
      for (n = 0; n < 900; n++) begin
         w = random_word(board.fill, 10);
         if (((n / 150) % 2) == 0 && $urandom_range(0, 2) == 0) w.cmd = CMD_INS_AT;
         if (((n / 150) % 2) == 1 && $urandom_range(0, 2) == 0) w.cmd = CMD_REM_AT;
         if ($urandom_range(0, 40) == 0) w.cmd = 4'($urandom_range(11, 15));
         send_word(w, (n % 200) > 180);
      end
      req_valid <= 0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("tb_bounded_positional_list_core OK");
      else
         $display("tb_bounded_positional_list_core NOT OK");
      $finish;
   end

endmodule

### files.f
+incdir+rtl/core
rtl/core/bpl_pkg.sv
rtl/core/bpl_ram.sv
rtl/core/bounded_positional_list_core.sv
bench/tb_bounded_positional_list_core.sv
